>>> src/llhm_pkg.sv
package llhm_pkg;

    // histogram geometry
    localparam int BUCKET_COUNT = 7;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int DATA_W       = 32;
    localparam int VER_W        = 8;
    localparam int PAGE_W       = 8;
    localparam int WORD_W       = 4;
    localparam int PADDR_W      = 3;

    // upper bounds (exclusive) of every bucket but the last, in microseconds
    localparam logic [DATA_W-1:0] BUCKET_LIMIT [BUCKET_COUNT-1] = '{
        32'd1000, 32'd2000, 32'd5000, 32'd10000, 32'd20000, 32'd50000
    };

    // register reset values
    localparam logic [DATA_W-1:0] LOG_EVERY_RST = 32'd8192;
    localparam logic [VER_W-1:0]  SNAP_VER_RST  = 8'd1;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_OVERLAY = 3'd1,
        OP_BRIDGE  = 3'd2,
        OP_RENDER  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_READ    = 3'd5,
        OP_LOG     = 3'd6,
        OP_NOP     = 3'd7
    } t_op;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_LOG_EVERY = 1'b0,
        REG_SNAP_VER  = 1'b1
    } t_reg;

    // snapshot pages
    localparam logic [PAGE_W-1:0] PAGE_SUMMARY = 8'd0;
    localparam logic [PAGE_W-1:0] PAGE_HIST    = 8'd1;

    // words of the summary page
    typedef enum logic [WORD_W-1:0] {
        SW_VERSION    = 4'd0,
        SW_ITER       = 4'd1,
        SW_OV_ITER    = 4'd2,
        SW_WORST      = 4'd3,
        SW_WORST_BR   = 4'd4,
        SW_WORST_RN   = 4'd5,
        SW_OV_WALL    = 4'd6,
        SW_OV_BRIDGE  = 4'd7,
        SW_OV_RENDER  = 4'd8
    } t_sum_word;

    typedef struct packed {
        logic [DATA_W-1:0] log_every;
        logic [VER_W-1:0]  snapshot_version;
    } t_cfg;

    // bucket index of one loop period
    function automatic logic [BKT_W-1:0] period_bucket(input logic [DATA_W-1:0] p);
        logic [BKT_W-1:0] b;
        b = BKT_W'(BUCKET_COUNT - 1);
        for (int i = BUCKET_COUNT - 2; i >= 0; i--) begin
            if (p < BUCKET_LIMIT[i]) b = BKT_W'(i);
        end
        return b;
    endfunction

endpackage

>>> src/llhm_in_if.sv
interface llhm_in_if;
    logic                                 valid;
    logic                                 ready;
    llhm_pkg::t_op                        op;
    logic [llhm_pkg::DATA_W-1:0]          timestamp_us;
    logic [llhm_pkg::DATA_W-1:0]          amount_us;
    logic [llhm_pkg::PAGE_W-1:0]          read_page;
    logic [llhm_pkg::WORD_W-1:0]          read_word;

    modport source (output valid, op, timestamp_us, amount_us, read_page, read_word,
                    input ready);
    modport sink   (input valid, op, timestamp_us, amount_us, read_page, read_word,
                    output ready);
endinterface

>>> src/llhm_out_if.sv
interface llhm_out_if;
    logic                        valid;
    logic                        ready;
    logic [llhm_pkg::DATA_W-1:0] read_data;
    logic                        read_valid;
    logic                        summary_due;

    modport source (output valid, read_data, read_valid, summary_due, input ready);
    modport sink   (input valid, read_data, read_valid, summary_due, output ready);
endinterface

>>> src/llhm_cfg.sv
module llhm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [llhm_pkg::PADDR_W-1:0]  paddr,
    input  logic [llhm_pkg::DATA_W-1:0]   pwdata,
    output logic [llhm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output llhm_pkg::t_cfg                o_cfg
);

    llhm_pkg::t_cfg r_cfg;
    llhm_pkg::t_reg w_sel;
    logic           w_wr;

    assign w_sel  = llhm_pkg::t_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_every        <= llhm_pkg::LOG_EVERY_RST;
            r_cfg.snapshot_version <= llhm_pkg::SNAP_VER_RST;
        end else if (w_wr) begin
            unique case (w_sel)
                llhm_pkg::REG_LOG_EVERY: r_cfg.log_every <= pwdata;
                llhm_pkg::REG_SNAP_VER:
                    r_cfg.snapshot_version <= pwdata[llhm_pkg::VER_W-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (w_sel)
            llhm_pkg::REG_LOG_EVERY: prdata = r_cfg.log_every;
            llhm_pkg::REG_SNAP_VER:
                prdata = {{(llhm_pkg::DATA_W-llhm_pkg::VER_W){1'b0}},
                          r_cfg.snapshot_version};
            default: prdata = '0;
        endcase
    end

endmodule

>>> src/loop_latency_histogram_monitor.sv
// Loop-period histogram monitor.
// An accepted input word passes the input register, then the result register, to
// its result word; a read returns the statistics as they stood before it. Throughput:
// one word per cycle unless o_out.ready stalls; all statistics update in the single
// compute stage. Reset (synchronous, active low) clears every statistic, disarms,
// zeroes the tick timestamp and loads log_every = 8192 and snapshot_version = 1.
module loop_latency_histogram_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    llhm_in_if.sink                       i_in,
    llhm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [llhm_pkg::PADDR_W-1:0]  paddr,
    input  logic [llhm_pkg::DATA_W-1:0]   pwdata,
    output logic [llhm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int DW = llhm_pkg::DATA_W;
    localparam int BC = llhm_pkg::BUCKET_COUNT;
    localparam int BW = llhm_pkg::BKT_W;

    llhm_pkg::t_cfg w_cfg;

    llhm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- input register ----------------
    logic                          r_in_vld;
    llhm_pkg::t_op                 r_op;
    logic [DW-1:0]                 r_ts;
    logic [DW-1:0]                 r_amt;
    logic [llhm_pkg::PAGE_W-1:0]   r_page;
    logic [llhm_pkg::WORD_W-1:0]   r_word;

    // ---------------- result register ----------------
    logic                          r_out_vld;
    logic [DW-1:0]                 r_rd_data;
    logic                          r_rd_valid;
    logic                          r_due;

    logic w_adv;   // compute stage hands its word to the result register
    logic w_go;    // an item is processed this cycle

    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_go       = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op   <= i_in.op;
            r_ts   <= i_in.timestamp_us;
            r_amt  <= i_in.amount_us;
            r_page <= i_in.read_page;
            r_word <= i_in.read_word;
        end
    end

    // ---------------- statistics state ----------------
    logic [DW-1:0] r_prev_ts, n_prev_ts;
    logic          r_armed, n_armed;
    logic [DW-1:0] r_it_br, n_it_br;
    logic [DW-1:0] r_it_rn, n_it_rn;
    logic          r_it_ov, n_it_ov;
    logic [DW-1:0] r_hist_nrm [BC];
    logic [DW-1:0] r_hist_ov  [BC];
    logic [DW-1:0] r_worst, n_worst;
    logic [DW-1:0] r_worst_br, n_worst_br;
    logic [DW-1:0] r_worst_rn, n_worst_rn;
    logic          r_worst_ov, n_worst_ov;
    logic [DW-1:0] r_ov_wall, n_ov_wall;
    logic [DW-1:0] r_ov_br, n_ov_br;
    logic [DW-1:0] r_ov_rn, n_ov_rn;
    logic [DW-1:0] r_iter, n_iter;
    logic [DW-1:0] r_ov_iter, n_ov_iter;
    logic [DW-1:0] r_cals, n_cals;

    // tick datapath
    logic [DW-1:0] w_dt;
    logic [BW-1:0] w_bkt;
    logic [DW-1:0] w_br_clamp;
    logic [DW-1:0] w_rem;
    logic [DW-1:0] w_rn_clamp;
    logic [DW-1:0] w_iter_inc;
    logic          w_rec;      // armed tick: period gets recorded
    logic          w_clear;

    assign w_dt       = r_ts - r_prev_ts;
    assign w_bkt      = llhm_pkg::period_bucket(w_dt);
    assign w_br_clamp = (r_it_br > w_dt) ? w_dt : r_it_br;
    assign w_rem      = w_dt - w_br_clamp;
    assign w_rn_clamp = (r_it_rn > w_rem) ? w_rem : r_it_rn;
    assign w_iter_inc = r_iter + 1'b1;
    assign w_rec      = w_go && (r_op == llhm_pkg::OP_TICK) && r_armed;
    assign w_clear    = w_go && (r_op == llhm_pkg::OP_CLEAR);

    logic [DW-1:0] n_rd_data;
    logic          n_rd_valid;
    logic          n_due;

    // next state of scalar statistics and the result word
    always_comb begin
        n_prev_ts  = r_prev_ts;
        n_armed    = r_armed;
        n_it_br    = r_it_br;
        n_it_rn    = r_it_rn;
        n_it_ov    = r_it_ov;
        n_worst    = r_worst;
        n_worst_br = r_worst_br;
        n_worst_rn = r_worst_rn;
        n_worst_ov = r_worst_ov;
        n_ov_wall  = r_ov_wall;
        n_ov_br    = r_ov_br;
        n_ov_rn    = r_ov_rn;
        n_iter     = r_iter;
        n_ov_iter  = r_ov_iter;
        n_cals     = r_cals;
        n_rd_data  = '0;
        n_rd_valid = 1'b0;
        n_due      = 1'b0;

        case (r_op)
            llhm_pkg::OP_TICK: begin
                if (r_armed) begin
                    if (r_it_ov) begin
                        n_ov_iter = r_ov_iter + 1'b1;
                        n_ov_wall = r_ov_wall + w_dt;
                        n_ov_br   = r_ov_br + w_br_clamp;
                        n_ov_rn   = r_ov_rn + w_rn_clamp;
                    end
                    n_iter = w_iter_inc;
                    if (w_dt > r_worst) begin
                        n_worst    = w_dt;
                        n_worst_br = r_it_br;
                        n_worst_rn = r_it_rn;
                        n_worst_ov = r_it_ov;
                    end
                    if ((w_iter_inc - r_cals) >= w_cfg.log_every) begin
                        n_cals = w_iter_inc;
                        n_due  = 1'b1;
                    end
                end
                n_prev_ts = r_ts;
                n_it_br   = '0;
                n_it_rn   = '0;
                n_it_ov   = 1'b0;
                n_armed   = 1'b1;
            end
            llhm_pkg::OP_OVERLAY: n_it_ov = 1'b1;
            llhm_pkg::OP_BRIDGE:  n_it_br = r_it_br + r_amt;
            llhm_pkg::OP_RENDER:  n_it_rn = r_it_rn + r_amt;
            llhm_pkg::OP_CLEAR: begin
                n_armed    = 1'b0;
                n_it_br    = '0;
                n_it_rn    = '0;
                n_it_ov    = 1'b0;
                n_worst    = '0;
                n_worst_br = '0;
                n_worst_rn = '0;
                n_worst_ov = 1'b0;
                n_ov_wall  = '0;
                n_ov_br    = '0;
                n_ov_rn    = '0;
                n_iter     = '0;
                n_ov_iter  = '0;
                n_cals     = '0;
            end
            llhm_pkg::OP_READ: begin
                if (r_page == llhm_pkg::PAGE_SUMMARY) begin
                    n_rd_valid = 1'b1;
                    unique case (r_word)
                        llhm_pkg::SW_VERSION:
                            n_rd_data = {{(DW-llhm_pkg::VER_W-1){1'b0}}, r_worst_ov,
                                         w_cfg.snapshot_version};
                        llhm_pkg::SW_ITER:      n_rd_data = r_iter;
                        llhm_pkg::SW_OV_ITER:   n_rd_data = r_ov_iter;
                        llhm_pkg::SW_WORST:     n_rd_data = r_worst;
                        llhm_pkg::SW_WORST_BR:  n_rd_data = r_worst_br;
                        llhm_pkg::SW_WORST_RN:  n_rd_data = r_worst_rn;
                        llhm_pkg::SW_OV_WALL:   n_rd_data = r_ov_wall;
                        llhm_pkg::SW_OV_BRIDGE: n_rd_data = r_ov_br;
                        llhm_pkg::SW_OV_RENDER: n_rd_data = r_ov_rn;
                        default:                n_rd_valid = 1'b0;
                    endcase
                end else if (r_page == llhm_pkg::PAGE_HIST) begin
                    // normal buckets first, then overlay buckets
                    if (r_word < llhm_pkg::WORD_W'(BC)) begin
                        n_rd_valid = 1'b1;
                        n_rd_data  = r_hist_nrm[r_word[BW-1:0]];
                    end else if (r_word < llhm_pkg::WORD_W'(2 * BC)) begin
                        n_rd_valid = 1'b1;
                        n_rd_data  = r_hist_ov[BW'(r_word - llhm_pkg::WORD_W'(BC))];
                    end
                end
            end
            llhm_pkg::OP_LOG: begin
                n_cals = r_iter;
                n_due  = 1'b1;
            end
            default: ;
        endcase
    end

    // scalar statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ts  <= '0;
            r_armed    <= 1'b0;
            r_it_br    <= '0;
            r_it_rn    <= '0;
            r_it_ov    <= 1'b0;
            r_worst    <= '0;
            r_worst_br <= '0;
            r_worst_rn <= '0;
            r_worst_ov <= 1'b0;
            r_ov_wall  <= '0;
            r_ov_br    <= '0;
            r_ov_rn    <= '0;
            r_iter     <= '0;
            r_ov_iter  <= '0;
            r_cals     <= '0;
        end else if (w_go) begin
            r_prev_ts  <= n_prev_ts;
            r_armed    <= n_armed;
            r_it_br    <= n_it_br;
            r_it_rn    <= n_it_rn;
            r_it_ov    <= n_it_ov;
            r_worst    <= n_worst;
            r_worst_br <= n_worst_br;
            r_worst_rn <= n_worst_rn;
            r_worst_ov <= n_worst_ov;
            r_ov_wall  <= n_ov_wall;
            r_ov_br    <= n_ov_br;
            r_ov_rn    <= n_ov_rn;
            r_iter     <= n_iter;
            r_ov_iter  <= n_ov_iter;
            r_cals     <= n_cals;
        end
    end

    // histogram bins: each counter bumps only on its own bucket hit
    for (genvar b = 0; b < BC; b++) begin : g_bin
        logic w_hit;
        assign w_hit = w_rec && (w_bkt == BW'(b));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || w_clear) begin
                r_hist_nrm[b] <= '0;
                r_hist_ov[b]  <= '0;
            end else if (w_hit) begin
                if (r_it_ov) begin
                    r_hist_ov[b] <= r_hist_ov[b] + 1'b1;
                end else begin
                    r_hist_nrm[b] <= r_hist_nrm[b] + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rd_data  <= n_rd_data;
            r_rd_valid <= n_rd_valid;
            r_due      <= n_due;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.read_data   = r_rd_data;
    assign o_out.read_valid  = r_rd_valid;
    assign o_out.summary_due = r_due;

endmodule
